/* sv/imd_pkg.sv */
package imd_pkg;

  localparam int unsigned Xlen = 32;
  localparam int unsigned CmdW = 3;

  typedef enum logic [CmdW-1:0] {
    CmdMul    = 3'd0,
    CmdMulh   = 3'd1,
    CmdMulhsu = 3'd2,
    CmdMulhu  = 3'd3,
    CmdDiv    = 3'd4,
    CmdDivu   = 3'd5,
    CmdRem    = 3'd6,
    CmdRemu   = 3'd7
  } cmd_e;

  // Sideband that travels down the divider pipeline with each word.
  typedef struct packed {
    logic            is_rem;
    logic            neg_q;
    logic            neg_r;
    logic            by_zero;
    logic [Xlen-1:0] dividend;
  } div_ctl_t;

endpackage

/* sv/imd_mul.sv */
// Signed 33x33 multiply from four partial products over three stages.
module imd_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      sel_hi_i,
  input  logic signed [imd_pkg::Xlen:0] a_i,
  input  logic signed [imd_pkg::Xlen:0] b_i,
  output logic [imd_pkg::Xlen-1:0]  res_o
);
  localparam int unsigned W = imd_pkg::Xlen;
  localparam int unsigned PW = 2 * W + 2;

  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [PW-1:0] sum_q;
  logic                 hi1_q, hi2_q;

  // Split a and b each into a low unsigned half and a high signed half.
  logic [W/2-1:0]          b_lo;
  logic signed [W/2:0]     b_hi;
  logic [W/2-1:0]          a_lo;
  logic signed [W/2:0]     a_hi;
  logic [W-1:0]            pa;
  logic signed [W+1:0]     pb, pc, pd;
  assign b_lo = b_i[W/2-1:0];
  assign b_hi = b_i[W:W/2];
  assign a_lo = a_i[W/2-1:0];
  assign a_hi = a_i[W:W/2];

  // Each partial product is formed at its full width before it is aligned.
  assign pa = a_lo * b_lo;
  assign pb = a_hi * $signed({1'b0, b_lo});
  assign pc = $signed({1'b0, a_lo}) * b_hi;
  assign pd = a_hi * b_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi1_q <= 1'b0;
      hi2_q <= 1'b0;
    end else if (adv_i) begin
      hi1_q <= sel_hi_i;
      hi2_q <= hi1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q  <= PW'(pa);
      pb_q  <= PW'(pb) <<< (W/2);
      pc_q  <= PW'(pc) <<< (W/2);
      pd_q  <= PW'(pd) <<< W;
      sum_q <= pa_q + pb_q + pc_q + pd_q;
      res_o <= hi2_q ? sum_q[2*W-1:W] : sum_q[W-1:0];
    end
  end
endmodule

/* sv/imd_div.sv */
// Unsigned restoring divider, one quotient bit per pipeline stage, with sign and divide-by-zero fixup on the result.
module imd_div (
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  logic [imd_pkg::Xlen-1:0] num_i,
  input  logic [imd_pkg::Xlen-1:0] den_i,
  input  imd_pkg::div_ctl_t        ctl_i,
  output logic [imd_pkg::Xlen-1:0] res_o
);
  localparam int unsigned W = imd_pkg::Xlen;

  logic [W-1:0]      q_q [W+1];
  logic [W-1:0]      r_q [W+1];
  logic [W-1:0]      d_q [W+1];
  imd_pkg::div_ctl_t c_q [W+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q_q[0] <= num_i;
      r_q[0] <= '0;
      d_q[0] <= den_i;
      c_q[0] <= ctl_i;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W:0] rem_sh;
    logic [W:0] diff;
    assign rem_sh = {r_q[s], q_q[s][W-1]};
    assign diff   = rem_sh - {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (!diff[W]) begin
          r_q[s+1] <= diff[W-1:0];
          q_q[s+1] <= {q_q[s][W-2:0], 1'b1};
        end else begin
          r_q[s+1] <= rem_sh[W-1:0];
          q_q[s+1] <= {q_q[s][W-2:0], 1'b0};
        end
        d_q[s+1] <= d_q[s];
        c_q[s+1] <= c_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (c_q[W].by_zero) begin
        res_o <= c_q[W].is_rem ? c_q[W].dividend : '1;
      end else if (c_q[W].is_rem) begin
        res_o <= c_q[W].neg_r ? W'(-r_q[W]) : r_q[W];
      end else begin
        res_o <= c_q[W].neg_q ? W'(-q_q[W]) : q_q[W];
      end
    end
  end
endmodule

/* sv/int_mul_div_unit.sv */
// RISC-V M extension multiply/divide unit. One word is accepted every cycle
// while the pipeline advances. The depth is set by the divider, which resolves
// one quotient bit per pipeline stage, and multiplies are delayed to match so
// results leave in order. The whole pipeline advances together and freezes
// when the output word is not taken.
module int_mul_div_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               command_i,
  input  logic [imd_pkg::Xlen-1:0] operand_a_i,
  input  logic [imd_pkg::Xlen-1:0] operand_b_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [imd_pkg::Xlen-1:0] result_o
);
  localparam int unsigned W = imd_pkg::Xlen;
  localparam int unsigned Lat = W + 2;
  localparam int unsigned MulLat = 3;

  logic adv;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] isdiv_q;
  logic [W-1:0]   mul_res, div_res;
  logic [W-1:0]   mdly_q [Lat-MulLat];
  logic [W-1:0]   res_q;
  logic           out_vld_q;
  imd_pkg::cmd_e  cmd;
  logic           a_sgn, b_sgn, is_div_cmd, sgn_div, by_zero;
  logic signed [W:0] ma, mb;
  logic [W-1:0]   num, den;
  imd_pkg::div_ctl_t ctl;

  assign adv = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_vld_q;
  assign result_o = res_q;
  assign cmd = imd_pkg::cmd_e'(command_i);

  always_comb begin
    a_sgn = 1'b0;
    b_sgn = 1'b0;
    case (cmd)
      imd_pkg::CmdMulh: begin
        a_sgn = 1'b1;
        b_sgn = 1'b1;
      end
      imd_pkg::CmdMulhsu: a_sgn = 1'b1;
      default: ;
    endcase
  end

  assign is_div_cmd = command_i[2];
  assign sgn_div = (cmd == imd_pkg::CmdDiv) || (cmd == imd_pkg::CmdRem);
  assign by_zero = (operand_b_i == '0);
  assign ma = {a_sgn & operand_a_i[W-1], operand_a_i};
  assign mb = {b_sgn & operand_b_i[W-1], operand_b_i};
  assign num = (sgn_div && operand_a_i[W-1]) ? W'(-operand_a_i) : operand_a_i;
  assign den = (sgn_div && operand_b_i[W-1]) ? W'(-operand_b_i) : operand_b_i;

  // Signed overflow falls out naturally: magnitude quotient 2^(W-1), no negate.
  always_comb begin
    ctl.is_rem   = command_i[1];
    ctl.neg_q    = sgn_div && (operand_a_i[W-1] ^ operand_b_i[W-1]);
    ctl.neg_r    = sgn_div && operand_a_i[W-1];
    ctl.by_zero  = by_zero;
    ctl.dividend = operand_a_i;
  end

  imd_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sel_hi_i (cmd != imd_pkg::CmdMul),
    .a_i      (ma),
    .b_i      (mb),
    .res_o    (mul_res)
  );

  imd_div u_div (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (num),
    .den_i (den),
    .ctl_i (ctl),
    .res_o (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mdly_q[0] <= mul_res;
      for (int i = 1; i < Lat - MulLat; i++) begin
        mdly_q[i] <= mdly_q[i-1];
      end
      res_q <= isdiv_q[Lat-1] ? div_res : mdly_q[Lat-MulLat-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      isdiv_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Lat-2:0], in_valid_i};
      isdiv_q   <= {isdiv_q[Lat-2:0], is_div_cmd};
      out_vld_q <= vld_q[Lat-1];
    end
  end
endmodule

/* dv/tb_int_mul_div_unit.sv */
module tb_int_mul_div_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LatencyCycles = imd_pkg::Xlen + 2;
  localparam int unsigned WatchdogLimit = 2000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               command_i = '0;
  logic [imd_pkg::Xlen-1:0] operand_a_i = '0;
  logic [imd_pkg::Xlen-1:0] operand_b_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [imd_pkg::Xlen-1:0] result_o;

  logic [imd_pkg::Xlen-1:0] expected_results[$];
  int unsigned     mismatch_count = 0;
  int unsigned     words_sent = 0;
  int unsigned     words_checked = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     out_wait = 0;
  int unsigned     cmd_hits[8];

  always #4 clk_i = ~clk_i;

  int_mul_div_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result_o)
  );

  function automatic logic [imd_pkg::Xlen-1:0] compute_mul_div(
      imd_pkg::cmd_e cmd, logic [imd_pkg::Xlen-1:0] a, logic [imd_pkg::Xlen-1:0] b);
    logic signed [2*imd_pkg::Xlen:0] sa, sb;
    logic [2*imd_pkg::Xlen+1:0]      prod;
    logic [imd_pkg::Xlen-1:0]        ma, mb, q, r;
    logic                            na, nb;
    na = a[imd_pkg::Xlen-1];
    nb = b[imd_pkg::Xlen-1];
    ma = na ? -a : a;
    mb = nb ? -b : b;
    case (cmd)
      imd_pkg::CmdMul: return a * b;
      imd_pkg::CmdMulh, imd_pkg::CmdMulhsu, imd_pkg::CmdMulhu: begin
        sa = (cmd == imd_pkg::CmdMulhu) ? $signed({{(imd_pkg::Xlen+1){1'b0}}, a})
                                        : $signed({{(imd_pkg::Xlen+1){na}}, a});
        sb = (cmd == imd_pkg::CmdMulh) ? $signed({{(imd_pkg::Xlen+1){nb}}, b})
                                       : $signed({{(imd_pkg::Xlen+1){1'b0}}, b});
        prod = sa * sb;
        return prod[2*imd_pkg::Xlen-1:imd_pkg::Xlen];
      end
      imd_pkg::CmdDivu: return (b == '0) ? '1 : a / b;
      imd_pkg::CmdRemu: return (b == '0) ? a : a % b;
      default: begin
        if (b == '0) return (cmd == imd_pkg::CmdDiv) ? '1 : a;
        q = ma / mb;
        r = ma % mb;
        if (cmd == imd_pkg::CmdDiv) return (na ^ nb) ? -q : q;
        return na ? -r : r;
      end
    endcase
  endfunction

  task automatic send_word(imd_pkg::cmd_e cmd, logic [imd_pkg::Xlen-1:0] a,
                           logic [imd_pkg::Xlen-1:0] b);
    int unsigned gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // Valid stays high when the next word goes out with no gap.
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    expected_results.push_back(compute_mul_div(cmd, a, b));
    cmd_hits[cmd]++;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  function automatic logic [imd_pkg::Xlen-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(imd_pkg::Xlen-1){1'b0}}};
      3: return {1'b0, {(imd_pkg::Xlen-1){1'b1}}};
      4: return $urandom_range(0, 15);
      5: return -$urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_corners();
    logic [imd_pkg::Xlen-1:0] min_neg;
    min_neg = {1'b1, {(imd_pkg::Xlen-1){1'b0}}};
    for (int c = 0; c < 8; c++) begin
      send_word(imd_pkg::cmd_e'(c), $urandom, '0);
      send_word(imd_pkg::cmd_e'(c), min_neg, '1);
    end
    send_word(imd_pkg::CmdMulhu, '1, '1);
    send_word(imd_pkg::CmdMulh, min_neg, min_neg);
    send_word(imd_pkg::CmdMulhsu, '1, '1);
    send_word(imd_pkg::CmdMulhsu, min_neg, '1);
    send_word(imd_pkg::CmdDiv, 32'd7, -32'sd2);
    send_word(imd_pkg::CmdRem, -32'sd7, 32'd2);
    send_word(imd_pkg::CmdDivu, '1, 32'd1);
    send_word(imd_pkg::CmdRemu, '0, '1);
  endtask

  task automatic test_random_words();
    for (int i = 0; i < 530; i++)
      send_word(imd_pkg::cmd_e'($urandom_range(0, 7)), pick_operand(), pick_operand());
  endtask

  // The result side waits a freshly drawn number of cycles before taking each word.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      out_wait = $urandom_range(0, 10);
      if (out_wait != 0) out_ready_i <= 1'b0;
    end else if (!out_ready_i) begin
      if (out_wait <= 1) out_ready_i <= 1'b1;
      else out_wait = out_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected word: got %h", result_o);
      end else begin
        if (result_o !== expected_results[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch on word %0d: expected %h, got %h",
                     words_checked, expected_results[0], result_o);
        end
        void'(expected_results.pop_front());
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d words outstanding", expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_random_words();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results, %0d mismatches.",
             words_sent, words_checked, mismatch_count);
    $display("Per-command counts MUL..REMU: %0d %0d %0d %0d %0d %0d %0d %0d",
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3],
             cmd_hits[4], cmd_hits[5], cmd_hits[6], cmd_hits[7]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
